// ----- hdl/ssg_pkg.sv -----
// shared types, constants and codes of the serial schedule generator
`timescale 1ns / 1ps
package ssg_pkg;

   // default sizes
   localparam int MAX_JOBS_DEF  = 64;
   localparam int HORIZON_DEF   = 256;
   localparam int RESOURCES_DEF = 4;

   // configuration register indexes
   localparam logic [2:0] REG_DIRECTION  = 3'd0;
   localparam logic [2:0] REG_CAPACITY_0 = 3'd1;
   localparam logic [2:0] REG_CAPACITY_1 = 3'd2;
   localparam logic [2:0] REG_CAPACITY_2 = 3'd3;
   localparam logic [2:0] REG_CAPACITY_3 = 3'd4;

   // one 8 bit lane per resource
   typedef logic [3:0][7:0] lane_array_type;

   // controller states
   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_START,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_PLACE,
      S_CHK_RD,
      S_CHK_CMP,
      S_BOOK_RD,
      S_BOOK_WR,
      S_TABLE,
      S_OUT
   } state_type;

   // datapath operations
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_CLEAR,
      OP_START,
      OP_SCAN_RD,
      OP_SCAN_CMP,
      OP_PLACE,
      OP_CHK_RD,
      OP_CHK_CMP,
      OP_BOOK_RD,
      OP_BOOK_WR,
      OP_TABLE,
      OP_OUT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic new_sched;
      logic pending;
      logic clr_last;
      logic bad;
      logic scan_last;
      logic place_fail;
      logic hz_fail;
      logic conflict;
      logic move_fail;
      logic chk_last;
      logic out_free;
   } status_type;

endpackage

// ----- hdl/serial_schedule_generator_unit.sv -----
// top level of the serial schedule generator: register port, sequencer and datapath
//
// Places one job per item on a slotted time line shared by up to four resources.
// Input channel req_*: a job with its duration, demands and related-job mask;
// req_new_schedule clears all placements and bookings before the job.
// Result channel rsp_*: one item per job with the job index, start slot and status
// (1 for a bad job index, a zero duration or no fitting slot inside the horizon; nothing is then booked).
// Register port csr_*: direction at 0x0, capacities 0..3 at 0x4..0x10.
// Per item the block scans every job table entry for related jobs, then tests and
// books the slots of the job one by one through the usage memory; a new schedule
// first clears the usage memory.
// One item is in work at a time; the next is taken once the result is registered.
// After reset the usage memory is cleared with req_stall high.
// A stalled result holds in the output register; the block finishes its next
// item and then waits in its final step until the result register is free.
`timescale 1ns / 1ps
module serial_schedule_generator_unit #(
   parameter int MAX_JOBS  = ssg_pkg::MAX_JOBS_DEF,
   parameter int HORIZON   = ssg_pkg::HORIZON_DEF,
   parameter int RESOURCES = ssg_pkg::RESOURCES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_new_schedule,
   input  logic [5:0]  req_job_id,
   input  logic [7:0]  req_duration,
   input  logic [63:0] req_related_mask,
   input  logic [7:0]  req_demand_0,
   input  logic [7:0]  req_demand_1,
   input  logic [7:0]  req_demand_2,
   input  logic [7:0]  req_demand_3,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_placed_job,
   output logic [7:0]  rsp_start_slot,
   output logic        rsp_status
);
   import ssg_pkg::*;

   logic           direction_ff, direction_in;
   lane_array_type capacity_ff, capacity_in;
   lane_array_type demand;
   logic           csr_write;
   logic [2:0]     csr_index;
   cmd_type        cmd;
   status_type     sts;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[4:2];

   // register writes
   always_comb begin
      direction_in = direction_ff;
      capacity_in  = capacity_ff;
      if (csr_write) begin
         case (csr_index)
            REG_DIRECTION:  direction_in   = csr_pwdata[0];
            REG_CAPACITY_0: capacity_in[0] = csr_pwdata[7:0];
            REG_CAPACITY_1: capacity_in[1] = csr_pwdata[7:0];
            REG_CAPACITY_2: capacity_in[2] = csr_pwdata[7:0];
            REG_CAPACITY_3: capacity_in[3] = csr_pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= 1'b0;
         capacity_ff  <= {4{8'hFF}};
      end else begin
         direction_ff <= direction_in;
         capacity_ff  <= capacity_in;
      end
   end

   // register reads
   always_comb begin
      case (csr_index)
         REG_DIRECTION:  csr_prdata = {31'd0, direction_ff};
         REG_CAPACITY_0: csr_prdata = {24'd0, capacity_ff[0]};
         REG_CAPACITY_1: csr_prdata = {24'd0, capacity_ff[1]};
         REG_CAPACITY_2: csr_prdata = {24'd0, capacity_ff[2]};
         REG_CAPACITY_3: csr_prdata = {24'd0, capacity_ff[3]};
         default:        csr_prdata = 32'd0;
      endcase
   end

   assign demand = {req_demand_3, req_demand_2, req_demand_1, req_demand_0};

   ssg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ssg_dpath #(
      .MAX_JOBS  (MAX_JOBS),
      .HORIZON   (HORIZON),
      .RESOURCES (RESOURCES)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .direction        (direction_ff),
      .capacity         (capacity_ff),
      .req_new_schedule (req_new_schedule),
      .req_job_id       (req_job_id),
      .req_duration     (req_duration),
      .req_related_mask (req_related_mask),
      .req_demand       (demand),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_placed_job   (rsp_placed_job),
      .rsp_start_slot   (rsp_start_slot),
      .rsp_status       (rsp_status)
   );

endmodule

// ----- hdl/ssg_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps
module ssg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/ssg_ctrl.sv -----
// sequencer of the schedule generator
`timescale 1ns / 1ps
module ssg_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  ssg_pkg::status_type sts,
   output ssg_pkg::cmd_type    cmd
);
   import ssg_pkg::*;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (sts.clr_last) state_in = sts.pending ? S_START : S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) state_in = sts.new_sched ? S_CLEAR : S_START;
         end
         S_START: begin
            state_in = sts.bad ? S_OUT : S_SCAN_RD;
         end
         S_SCAN_RD: state_in = S_SCAN_CMP;
         S_SCAN_CMP: begin
            state_in = sts.scan_last ? S_PLACE : S_SCAN_RD;
         end
         S_PLACE: begin
            state_in = sts.place_fail ? S_OUT : S_CHK_RD;
         end
         S_CHK_RD: begin
            state_in = sts.hz_fail ? S_OUT : S_CHK_CMP;
         end
         S_CHK_CMP: begin
            if (sts.conflict) state_in = sts.move_fail ? S_OUT : S_CHK_RD;
            else              state_in = sts.chk_last ? S_BOOK_RD : S_CHK_RD;
         end
         S_BOOK_RD: state_in = S_BOOK_WR;
         S_BOOK_WR: begin
            state_in = sts.chk_last ? S_TABLE : S_BOOK_RD;
         end
         S_TABLE: state_in = S_OUT;
         S_OUT: begin
            if (sts.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd.op    = OP_NONE;
      req_stall = 1'b1;
      case (state_ff)
         S_CLEAR:    cmd.op = OP_CLEAR;
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) cmd.op = OP_LOAD;
         end
         S_START:    cmd.op = OP_START;
         S_SCAN_RD:  cmd.op = OP_SCAN_RD;
         S_SCAN_CMP: cmd.op = OP_SCAN_CMP;
         S_PLACE:    cmd.op = OP_PLACE;
         S_CHK_RD:   cmd.op = OP_CHK_RD;
         S_CHK_CMP:  cmd.op = OP_CHK_CMP;
         S_BOOK_RD:  cmd.op = OP_BOOK_RD;
         S_BOOK_WR:  cmd.op = OP_BOOK_WR;
         S_TABLE:    cmd.op = OP_TABLE;
         S_OUT:      cmd.op = OP_OUT;
         default:    cmd.op = OP_NONE;
      endcase
   end

endmodule

// ----- hdl/ssg_dpath.sv -----
// datapath: item registers, job tables, resource usage memory and result register
`timescale 1ns / 1ps
module ssg_dpath #(
   parameter int MAX_JOBS  = ssg_pkg::MAX_JOBS_DEF,
   parameter int HORIZON   = ssg_pkg::HORIZON_DEF,
   parameter int RESOURCES = ssg_pkg::RESOURCES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ssg_pkg::cmd_type        cmd,
   output ssg_pkg::status_type     sts,
   input  logic                    direction,
   input  ssg_pkg::lane_array_type capacity,
   input  logic                    req_new_schedule,
   input  logic [5:0]              req_job_id,
   input  logic [7:0]              req_duration,
   input  logic [63:0]             req_related_mask,
   input  ssg_pkg::lane_array_type req_demand,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [5:0]              rsp_placed_job,
   output logic [7:0]              rsp_start_slot,
   output logic                    rsp_status
);
   import ssg_pkg::*;

   localparam int JW = $clog2(MAX_JOBS);
   localparam int SW = $clog2(HORIZON);
   localparam int TW = $clog2(HORIZON + 1);
   localparam int XW = ((TW > 8) ? TW : 8) + 1;
   localparam int RW = 8 * RESOURCES;

   // item registers
   logic [5:0]          job_ff, job_in;
   logic [7:0]          dur_ff, dur_in;
   logic [MAX_JOBS-1:0] mask_ff, mask_in;
   lane_array_type      dem_ff, dem_in;
   logic                fail_ff, fail_in;
   logic                pend_ff, pend_in;
   // sequencing registers
   logic [JW-1:0]       scan_j_ff, scan_j_in;
   logic [TW-1:0]       best_ff, best_in;
   logic [TW-1:0]       s_ff, s_in;
   logic [7:0]          t_ff, t_in;
   logic [SW-1:0]       clr_ff, clr_in;
   logic [MAX_JOBS-1:0] placed_ff, placed_in;
   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [5:0]          rsp_job_ff, rsp_job_in;
   logic [7:0]          rsp_start_ff, rsp_start_in;
   logic                rsp_status_ff, rsp_status_in;

   // memory ports
   logic          tbl_we, tbl_re, res_we, res_re;
   logic [SW-1:0] start_rd;
   logic [TW-1:0] finish_rd;
   logic [RW-1:0] used_rd, res_wdata;
   logic [SW-1:0] res_waddr;

   // derived values
   logic [JW-1:0] job_idx;
   logic [XW-1:0] s_x, t_x, dur_x, best_x;
   logic [SW-1:0] slot_addr;
   logic          bad, conflict, out_free;
   logic [RW-1:0] booked;

   assign job_idx   = job_ff[JW-1:0];
   assign s_x       = XW'(s_ff);
   assign t_x       = XW'(t_ff);
   assign dur_x     = XW'(dur_ff);
   assign best_x    = XW'(best_ff);
   assign slot_addr = SW'(s_x + t_x);
   assign bad       = (7'(job_ff) >= 7'(MAX_JOBS)) || (dur_ff == 8'd0);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // capacity check and booked usage for one slot row
   always_comb begin
      conflict = 1'b0;
      booked   = used_rd;
      for (int r = 0; r < RESOURCES; r++) begin
         if ({1'b0, capacity[r]} < ({1'b0, used_rd[8*r +: 8]} + {1'b0, dem_ff[r]})) begin
            conflict = 1'b1;
         end
         booked[8*r +: 8] = used_rd[8*r +: 8] + dem_ff[r];
      end
   end

   // status to the sequencer
   always_comb begin
      sts.new_sched  = req_new_schedule;
      sts.pending    = pend_ff;
      sts.clr_last   = (clr_ff == SW'(HORIZON - 1));
      sts.bad        = bad;
      sts.scan_last  = (scan_j_ff == JW'(MAX_JOBS - 1));
      sts.place_fail = direction && (best_x < dur_x);
      sts.hz_fail    = !direction && ((s_x + dur_x) > XW'(HORIZON));
      sts.conflict   = conflict;
      sts.move_fail  = direction && (s_x < (dur_x - t_x));
      sts.chk_last   = ((t_ff + 8'd1) == dur_ff);
      sts.out_free   = out_free;
   end

   // operations
   always_comb begin
      job_in        = job_ff;
      dur_in        = dur_ff;
      mask_in       = mask_ff;
      dem_in        = dem_ff;
      fail_in       = fail_ff;
      pend_in       = pend_ff;
      scan_j_in     = scan_j_ff;
      best_in       = best_ff;
      s_in          = s_ff;
      t_in          = t_ff;
      clr_in        = clr_ff;
      placed_in     = placed_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_job_in    = rsp_job_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_status_in = rsp_status_ff;
      tbl_we        = 1'b0;
      tbl_re        = 1'b0;
      res_we        = 1'b0;
      res_re        = 1'b0;
      res_waddr     = slot_addr;
      res_wdata     = booked;
      case (cmd.op)
         OP_LOAD: begin
            job_in  = req_job_id;
            dur_in  = req_duration;
            mask_in = req_related_mask[MAX_JOBS-1:0];
            dem_in  = req_demand;
            fail_in = 1'b0;
            pend_in = 1'b1;
            clr_in  = '0;
            if (req_new_schedule) placed_in = '0;
         end
         OP_CLEAR: begin
            res_we    = 1'b1;
            res_waddr = clr_ff;
            res_wdata = '0;
            clr_in    = clr_ff + SW'(1);
         end
         OP_START: begin
            scan_j_in = '0;
            best_in   = direction ? TW'(HORIZON) : '0;
         end
         OP_SCAN_RD: tbl_re = 1'b1;
         OP_SCAN_CMP: begin
            // related and already placed jobs bound the placement
            if (mask_ff[scan_j_ff] && placed_ff[scan_j_ff]) begin
               if (direction) begin
                  if (XW'(start_rd) < best_x) best_in = TW'(start_rd);
               end else begin
                  if (finish_rd > best_ff) best_in = finish_rd;
               end
            end
            scan_j_in = scan_j_ff + JW'(1);
         end
         OP_PLACE: begin
            t_in = '0;
            if (direction) begin
               if (best_x < dur_x) fail_in = 1'b1;
               else                s_in    = TW'(best_x - dur_x);
            end else begin
               s_in = best_ff;
            end
         end
         OP_CHK_RD: begin
            if (sts.hz_fail) fail_in = 1'b1;
            else             res_re  = 1'b1;
         end
         OP_CHK_CMP: begin
            if (conflict) begin
               t_in = '0;
               if (direction) begin
                  if (sts.move_fail) fail_in = 1'b1;
                  else               s_in    = TW'(s_x - (dur_x - t_x));
               end else begin
                  s_in = TW'(s_x + t_x + XW'(1));
               end
            end else begin
               t_in = sts.chk_last ? 8'd0 : t_ff + 8'd1;
            end
         end
         OP_BOOK_RD: res_re = 1'b1;
         OP_BOOK_WR: begin
            res_we = 1'b1;
            t_in   = t_ff + 8'd1;
         end
         OP_TABLE: begin
            tbl_we             = 1'b1;
            placed_in[job_idx] = 1'b1;
         end
         OP_OUT: begin
            if (out_free) begin
               pend_in      = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_job_in   = job_ff;
               if (fail_ff || bad) begin
                  rsp_start_in  = 8'd0;
                  rsp_status_in = 1'b1;
                  if (!bad) placed_in[job_idx] = 1'b0;
               end else begin
                  rsp_start_in  = 8'(s_ff);
                  rsp_status_in = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         clr_ff       <= '0;
         placed_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         clr_ff       <= clr_in;
         placed_ff    <= placed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      job_ff        <= job_in;
      dur_ff        <= dur_in;
      mask_ff       <= mask_in;
      dem_ff        <= dem_in;
      fail_ff       <= fail_in;
      scan_j_ff     <= scan_j_in;
      best_ff       <= best_in;
      s_ff          <= s_in;
      t_ff          <= t_in;
      rsp_job_ff    <= rsp_job_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_status_ff <= rsp_status_in;
   end

   // start and finish of each placed job
   ssg_ram #(.WIDTH(SW), .DEPTH(MAX_JOBS)) u_start_ram (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (job_idx),
      .wr_data (SW'(s_ff)),
      .rd_en   (tbl_re),
      .rd_addr (scan_j_ff),
      .rd_data (start_rd)
   );

   ssg_ram #(.WIDTH(TW), .DEPTH(MAX_JOBS)) u_finish_ram (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (job_idx),
      .wr_data (TW'(s_x + dur_x)),
      .rd_en   (tbl_re),
      .rd_addr (scan_j_ff),
      .rd_data (finish_rd)
   );

   // resource usage, one row of all resources per slot
   ssg_ram #(.WIDTH(RW), .DEPTH(HORIZON)) u_used_ram (
      .clock   (clock),
      .wr_en   (res_we),
      .wr_addr (res_waddr),
      .wr_data (res_wdata),
      .rd_en   (res_re),
      .rd_addr (slot_addr),
      .rd_data (used_rd)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_placed_job = rsp_job_ff;
   assign rsp_start_slot = rsp_start_ff;
   assign rsp_status     = rsp_status_ff;

endmodule
